@@ hw/rtl/pdb_pkg.sv @@
// Shared types, widths and constants of the pixel deviation block.
`timescale 1ns / 1ps
`default_nettype none

package pdb_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned IDX_W      = 19;
  localparam int unsigned SQ_W       = 16;
  localparam int unsigned SUM_W      = 22;
  localparam int unsigned FC_W       = 7;
  localparam int unsigned DIV_W      = 7;
  localparam int unsigned ODD_SQ_W   = 18;
  localparam int unsigned EDGE_W     = ODD_SQ_W + DIV_W;
  localparam int unsigned FOUR_S_W   = SUM_W + 2;
  localparam int unsigned ROOT_W     = 8;

  localparam logic [SUM_W-1:0] SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [FC_W-1:0]  FC_RESET = FC_W'(8);

  localparam int unsigned DEF_PIXEL_COUNT = 307200;
  localparam int unsigned DEF_MAX_FRAMES  = 64;

  // Queue depths; both must be powers of two.
  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 16;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic [PIX_W-1:0] background_value;
    logic [IDX_W-1:0] pixel_index;
    logic             first_frame;
    logic             last_frame;
  } in_t;

  typedef struct packed {
    logic [ROOT_W-1:0] deviation;
    logic [IDX_W-1:0]  result_index;
  } out_t;

  // Work handed from the accumulate side to the root side.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [DIV_W-1:0] div;
    logic [IDX_W-1:0] idx;
  } job_t;

endpackage

`default_nettype wire

@@ hw/rtl/pdb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module pdb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and read-first registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hw/rtl/pdb_fifo.sv @@
// Small register FIFO with the head shown combinationally and a fill count.
`timescale 1ns / 1ps
`default_nettype none

module pdb_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  empty_o,
  output logic      [CW-1:0]    count_o
);

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  always_comb begin
    wptr_d = push_i ? wptr_q + PW'(1) : wptr_q;
    rptr_d = pop_i  ? rptr_q + PW'(1) : rptr_q;
    cnt_d  = cnt_q + CW'(push_i) - CW'(pop_i);
  end

  // Pointer and count registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o = buf_q[rptr_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule

`default_nettype wire

@@ hw/rtl/pdb_front.sv @@
// Accumulate side: squares the difference and updates the per-pixel sum store.
`timescale 1ns / 1ps
`default_nettype none

module pdb_front #(
  parameter int unsigned PIXEL_COUNT = pdb_pkg::DEF_PIXEL_COUNT,
  parameter int unsigned MAX_FRAMES  = pdb_pkg::DEF_MAX_FRAMES
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire pdb_pkg::in_t                  item_i,
  input  wire logic [pdb_pkg::FC_W-1:0]      series_len_i,
  output logic                               busy_o,
  output logic                               job_push_o,
  output pdb_pkg::job_t                      job_o
);

  import pdb_pkg::*;

  localparam int unsigned AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int unsigned XW = 23;

  logic             in_range;
  logic [PIX_W-1:0] diff;
  logic [XW-1:0]    idx_ext_in, idx_ext_s1, idx_ext_wr;

  logic             s1_v_q, s1_first_q, s1_last_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic [SQ_W-1:0]  s1_sq_q;

  logic             wr_v_q;
  logic [IDX_W-1:0] wr_idx_q;
  logic [SUM_W-1:0] wr_sum_q;

  logic [SUM_W-1:0] rdata, old_sum, new_sum;
  logic [SUM_W:0]   add_sum;
  logic [31:0]      fc_clamped;

  // Entry stage: range check and absolute difference.
  assign in_range   = 32'(item_i.pixel_index) < 32'(PIXEL_COUNT);
  assign diff       = (item_i.pixel_value >= item_i.background_value)
                    ? item_i.pixel_value - item_i.background_value
                    : item_i.background_value - item_i.pixel_value;
  assign idx_ext_in = XW'(item_i.pixel_index);
  assign idx_ext_s1 = XW'(s1_idx_q);
  assign idx_ext_wr = XW'(wr_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      wr_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept_i && in_range;
      wr_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q   <= item_i.pixel_index;
    s1_first_q <= item_i.first_frame;
    s1_last_q  <= item_i.last_frame;
    s1_sq_q    <= SQ_W'(diff) * SQ_W'(diff);
    wr_idx_q   <= s1_idx_q;
    wr_sum_q   <= new_sum;
  end

  pdb_ram #(
    .WIDTH (SUM_W),
    .DEPTH (PIXEL_COUNT)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (s1_v_q),
    .waddr_i (idx_ext_s1[AW-1:0]),
    .wdata_i (new_sum),
    .raddr_i (idx_ext_in[AW-1:0]),
    .rdata_o (rdata)
  );

  // Update stage: the write of the previous cycle is not yet in the read data.
  assign old_sum = (wr_v_q && idx_ext_wr == idx_ext_s1) ? wr_sum_q : rdata;
  assign add_sum = {1'b0, old_sum} + (SUM_W + 1)'(s1_sq_q);

  always_comb begin
    if (s1_first_q) begin
      new_sum = SUM_W'(s1_sq_q);
    end else if (add_sum > {1'b0, SUM_MAX}) begin
      new_sum = SUM_MAX;
    end else begin
      new_sum = add_sum[SUM_W-1:0];
    end
  end

  // Divisor from the clamped series length.
  always_comb begin
    fc_clamped = 32'(series_len_i);
    if (fc_clamped < 32'd2) begin
      fc_clamped = 32'd2;
    end
    if (fc_clamped > 32'(MAX_FRAMES)) begin
      fc_clamped = 32'(MAX_FRAMES);
    end
  end

  assign job_push_o = s1_v_q && s1_last_q;
  assign job_o.sum  = new_sum;
  assign job_o.div  = DIV_W'(fc_clamped - 32'd1);
  assign job_o.idx  = s1_idx_q;
  assign busy_o     = s1_v_q;

endmodule

`default_nettype wire

@@ hw/rtl/pdb_back.sv @@
// Root side: eight-stage bit-per-stage search for the rounded square root of sum/div.
`timescale 1ns / 1ps
`default_nettype none

module pdb_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_valid_i,
  input  wire pdb_pkg::job_t job_i,
  output logic               res_valid_o,
  output pdb_pkg::out_t      res_o
);

  import pdb_pkg::*;

  localparam int unsigned STAGES = ROOT_W;

  logic [ODD_SQ_W-1:0] odd_sq [256];

  logic                v_q    [STAGES+1];
  logic [FOUR_S_W-1:0] four_q [STAGES+1];
  logic [DIV_W-1:0]    div_q  [STAGES+1];
  logic [ROOT_W-1:0]   root_q [STAGES+1];
  logic [IDX_W-1:0]    idx_q  [STAGES+1];

  // Constant table of (2k+1)^2.
  for (genvar g = 0; g < 256; g++) begin : g_tab
    assign odd_sq[g] = ODD_SQ_W'((2 * g + 1) * (2 * g + 1));
  end

  // Stage zero takes the job.
  always_comb begin
    v_q[0]    = job_valid_i;
    four_q[0] = {job_i.sum, 2'b00};
    div_q[0]  = job_i.div;
    root_q[0] = '0;
    idx_q[0]  = job_i.idx;
  end

  // Each stage tries one more root bit: keep it if 4S lies above the rounding edge, or on it when k is odd.
  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    logic [ROOT_W-1:0] cand, k;
    logic [EDGE_W-1:0] edge_val;
    logic [EDGE_W-1:0] four_ext;
    logic              take;

    assign cand     = root_q[j] | ROOT_W'(1 << (STAGES - 1 - j));
    assign k        = cand - ROOT_W'(1);
    assign edge_val = EDGE_W'(div_q[j]) * EDGE_W'(odd_sq[k]);
    assign four_ext = EDGE_W'(four_q[j]);
    assign take     = (four_ext > edge_val) || (four_ext == edge_val && k[0]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      four_q[j+1] <= four_q[j];
      div_q[j+1]  <= div_q[j];
      root_q[j+1] <= take ? cand : root_q[j];
      idx_q[j+1]  <= idx_q[j];
    end
  end

  assign res_valid_o        = v_q[STAGES];
  assign res_o.deviation    = root_q[STAGES];
  assign res_o.result_index = idx_q[STAGES];

endmodule

`default_nettype wire

@@ hw/rtl/pixel_deviation_from_background.sv @@
// Top level of the per-pixel deviation block.
`timescale 1ns / 1ps
`default_nettype none

// Takes one pixel per clock while full is low, with its background value and raster
// index, and keeps a per-pixel sum of squared differences in an on-chip RAM of
// PIXEL_COUNT words; a last-frame pixel yields the rounded square root of
// sum/(clamped series length - 1), saturated at 255. Sustained rate is one pixel per
// cycle, set by the single read and single write port of the sum RAM; a result passes
// the entry register, the middle queue and the root stages into the output queue.
// The sum RAM has no reset and needs no clearing pass: every pixel must see a first
// frame before any later frame. The user must write the series length through the
// configuration channel only while the block is idle; the block does not enforce it.
module pixel_deviation_from_background #(
  parameter int unsigned PIXEL_COUNT = pdb_pkg::DEF_PIXEL_COUNT,
  parameter int unsigned MAX_FRAMES  = pdb_pkg::DEF_MAX_FRAMES
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     push,
  output logic                          full,
  input  wire pdb_pkg::in_t             in_item_i,
  output logic                          empty,
  input  wire logic                     pop,
  output pdb_pkg::out_t                 out_item_o,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [pdb_pkg::FC_W-1:0] cfg_data_i
);

  import pdb_pkg::*;

  localparam int unsigned MCW = $clog2(MID_DEPTH + 1);
  localparam int unsigned OCW = $clog2(OUT_DEPTH + 1);

  logic [FC_W-1:0] series_len_q;
  logic            accept, front_busy, job_push, job_pop, mid_empty;
  logic            res_valid, out_empty;
  job_t            job_in, job_out;
  out_t            res;
  logic [MCW-1:0]  mid_count;
  logic [OCW-1:0]  out_count;
  logic [OCW-1:0]  back_cnt_q, back_cnt_d;

  // Configuration register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      series_len_q <= FC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      series_len_q <= cfg_data_i;
    end
  end

  // Input transaction: room is kept for the item in flight plus the new one.
  assign full   = (32'(mid_count) + 32'(front_busy)) >= 32'(MID_DEPTH - 1);
  assign accept = push && !full;

  pdb_front #(
    .PIXEL_COUNT (PIXEL_COUNT),
    .MAX_FRAMES  (MAX_FRAMES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .item_i       (in_item_i),
    .series_len_i (series_len_q),
    .busy_o       (front_busy),
    .job_push_o   (job_push),
    .job_o        (job_in)
  );

  pdb_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (job_in),
    .pop_i   (job_pop),
    .rdata_o (job_out),
    .empty_o (mid_empty),
    .count_o (mid_count)
  );

  // Credit count of jobs in the root pipeline plus the output queue.
  assign job_pop    = !mid_empty && (32'(back_cnt_q) < 32'(OUT_DEPTH));
  assign back_cnt_d = back_cnt_q + OCW'(job_pop) - OCW'(pop && !out_empty);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      back_cnt_q <= '0;
    end else begin
      back_cnt_q <= back_cnt_d;
    end
  end

  pdb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_pop),
    .job_i       (job_out),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  pdb_fifo #(
    .WIDTH ($bits(out_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .wdata_i (res),
    .pop_i   (pop && !out_empty),
    .rdata_o (out_item_o),
    .empty_o (out_empty),
    .count_o (out_count)
  );

  assign empty = out_empty || (out_count == '0);

endmodule

`default_nettype wire

@@ tb/sv/pixel_deviation_from_background_tb.sv @@
// Self-checking testbench for the per-pixel deviation block.
`timescale 1ns / 1ps

module pixel_deviation_from_background_tb;
  import pdb_pkg::*;

  localparam int unsigned PIXELS      = DEF_PIXEL_COUNT;
  localparam int unsigned FRAMES_MAX  = DEF_MAX_FRAMES;
  localparam int unsigned DRAIN_WAIT  = 30;
  localparam int unsigned ITEM_TARGET = 500;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  in_t in_item_i = '0;
  logic empty;
  logic pop = 1'b0;
  out_t out_item_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [FC_W-1:0] cfg_data_i = '0;

  // Pixels waiting to be offered, expected deviations, and the predictor state.
  in_t pending_pixels[$];
  out_t expected_devs[$];
  logic [SUM_W-1:0] sum_by_pixel[int unsigned];
  logic [FC_W-1:0] frames_setting = FC_RESET;
  bit written_pixel[int unsigned];
  bit pixel_taken = 1'b0;
  int unsigned send_gap = 0;
  int unsigned pop_gap = 0;
  int unsigned errors = 0;
  int unsigned generated = 0;

  pixel_deviation_from_background u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .empty     (empty),
    .pop       (pop),
    .out_item_o(out_item_o),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data_i(cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Nearest integer to sqrt(sum/div), ties to even, saturated at 255.
  function automatic logic [ROOT_W-1:0] rounded_root(logic [SUM_W-1:0] sum,
                                                     int unsigned div);
    longint unsigned four_sum;
    longint unsigned odd;
    int unsigned root;
    four_sum = 64'(sum) * 4;
    root = 0;
    for (int unsigned k = 0; k < 255; k++) begin
      odd = 2 * k + 1;
      if (four_sum > div * odd * odd) root++;
      else if (four_sum == div * odd * odd && k[0]) root++;
    end
    return root[ROOT_W-1:0];
  endfunction

  // Update the running sum of one pixel and queue its deviation on the last frame.
  function automatic void accumulate_pixel(in_t px);
    logic [PIX_W-1:0] diff;
    int unsigned total;
    int unsigned fc;
    out_t dev;
    if (px.pixel_index >= PIXELS) return;
    diff = (px.pixel_value >= px.background_value) ?
           px.pixel_value - px.background_value : px.background_value - px.pixel_value;
    total = diff * diff;
    if (!px.first_frame) begin
      total += sum_by_pixel.exists(px.pixel_index) ? sum_by_pixel[px.pixel_index] : 0;
      if (total > SUM_MAX) total = SUM_MAX;
    end
    sum_by_pixel[px.pixel_index] = total[SUM_W-1:0];
    if (!px.last_frame) return;
    fc = frames_setting;
    if (fc < 2) fc = 2;
    if (fc > FRAMES_MAX) fc = FRAMES_MAX;
    dev.deviation = rounded_root(total[SUM_W-1:0], fc - 1);
    dev.result_index = px.pixel_index;
    expected_devs.push_back(dev);
  endfunction

  // Observe both handshakes at the rising edge.
  always @(posedge clk_i) begin
    pixel_taken = push && !full;
    if (pixel_taken) accumulate_pixel(in_item_i);
    if (pop && !empty) begin
      if (expected_devs.size() == 0) begin
        $display("%0t: unexpected result, actual dev=%0d idx=%0d", $time,
                 out_item_o.deviation, out_item_o.result_index);
        errors++;
      end else begin
        if (out_item_o.deviation !== expected_devs[0].deviation) begin
          $display("%0t: deviation mismatch, expected %0d actual %0d (idx %0d)", $time,
                   expected_devs[0].deviation, out_item_o.deviation,
                   expected_devs[0].result_index);
          errors++;
        end
        if (out_item_o.result_index !== expected_devs[0].result_index) begin
          $display("%0t: result_index mismatch, expected %0d actual %0d", $time,
                   expected_devs[0].result_index, out_item_o.result_index);
          errors++;
        end
        void'(expected_devs.pop_front());
      end
    end
  end

  // Pixel driver: holds an offered transaction until it is taken.
  always @(negedge clk_i) begin
    if (rst_ni && !(push && !pixel_taken)) begin
      if (send_gap > 0 || pending_pixels.size() == 0) begin
        if (send_gap > 0) send_gap--;
        push <= 1'b0;
      end else begin
        in_item_i <= pending_pixels.pop_front();
        push <= 1'b1;
        send_gap = idle_length();
      end
    end
  end

  // Result side: random stalls with a long one now and then.
  always @(negedge clk_i) begin
    if (pop_gap > 0) begin
      pop_gap--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 3) == 0) pop_gap = idle_length();
    end
  end

  function automatic in_t make_pixel(int unsigned idx, bit first, bit last);
    in_t px;
    px.pixel_value = PIX_W'($urandom_range(0, 255));
    px.background_value = PIX_W'($urandom_range(0, 255));
    px.pixel_index = IDX_W'(idx);
    px.first_frame = first;
    px.last_frame = last;
    if (idx < PIXELS && first) written_pixel[idx] = 1'b1;
    generated++;
    return px;
  endfunction

  // A well-formed series: a few pixels in raster order over several frames.
  task automatic queue_series(int unsigned n_pix, int unsigned n_frames);
    int unsigned idx[$];
    int unsigned base;
    base = ($urandom_range(0, 9) == 0) ? PIXELS - n_pix : $urandom_range(0, PIXELS - n_pix);
    for (int unsigned p = 0; p < n_pix; p++) idx.push_back(base + p);
    for (int unsigned f = 0; f < n_frames; f++)
      foreach (idx[p]) pending_pixels.push_back(make_pixel(idx[p], f == 0, f == n_frames - 1));
  endtask

  // Noise: out-of-range pixels, stray restarts, and extra frames on known pixels.
  task automatic queue_noise();
    int unsigned keys[$];
    in_t px;
    case ($urandom_range(0, 2))
      0: pending_pixels.push_back(make_pixel($urandom_range(PIXELS, (1 << IDX_W) - 1),
                                             $urandom_range(0, 1), $urandom_range(0, 1)));
      1: pending_pixels.push_back(make_pixel($urandom_range(0, PIXELS - 1), 1'b1,
                                             $urandom_range(0, 1)));
      default: begin
        foreach (written_pixel[k]) keys.push_back(k);
        px = make_pixel(keys[$urandom_range(0, keys.size() - 1)], 1'b0, $urandom_range(0, 1));
        pending_pixels.push_back(px);
      end
    endcase
  endtask

  // Let every queued pixel go through and every expected result come back.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_pixels.size() != 0 || push || expected_devs.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_series_len(logic [FC_W-1:0] value);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i);
    while (!cfg_ready);
    frames_setting = value;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [FC_W-1:0] settings[8];
    in_t px;
    settings = '{FC_W'(8), FC_W'(2), FC_W'(64), FC_W'(0), FC_W'(1), FC_W'(127), FC_W'(3),
                 FC_W'(33)};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes of the pixel fields, first and last together.
    px = make_pixel(0, 1'b1, 1'b1);
    px.pixel_value = 8'd255;
    px.background_value = 8'd0;
    pending_pixels.push_back(px);
    px = make_pixel(PIXELS - 1, 1'b1, 1'b1);
    px.pixel_value = 8'd0;
    px.background_value = 8'd255;
    pending_pixels.push_back(px);
    px = make_pixel(1, 1'b1, 1'b1);
    px.pixel_value = 8'd77;
    px.background_value = 8'd77;
    pending_pixels.push_back(px);
    // Index just past the frame and the largest index are ignored.
    pending_pixels.push_back(make_pixel(PIXELS, 1'b1, 1'b1));
    pending_pixels.push_back(make_pixel((1 << IDX_W) - 1, 1'b0, 1'b1));
    // Non-last frames produce nothing until the last one.
    queue_series(3, 3);
    wait_idle();

    // Sum saturation: maximal difference on one pixel for more than 64 frames.
    for (int unsigned f = 0; f < 66; f++) begin
      px = make_pixel(5, f == 0, f == 65);
      px.pixel_value = 8'd255;
      px.background_value = 8'd0;
      pending_pixels.push_back(px);
    end
    wait_idle();

    // Random phases, one series-length setting each; the sender waits in between.
    generated = 0;
    foreach (settings[s]) begin
      write_series_len(settings[s]);
      while (generated < (s + 1) * ITEM_TARGET / 8) begin
        if ($urandom_range(0, 4) == 0) queue_noise();
        else queue_series($urandom_range(1, 4), $urandom_range(1, 6));
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ pixel_deviation_from_background.f @@
hw/rtl/pdb_pkg.sv
hw/rtl/pdb_ram.sv
hw/rtl/pdb_fifo.sv
hw/rtl/pdb_front.sv
hw/rtl/pdb_back.sv
hw/rtl/pixel_deviation_from_background.sv
tb/sv/pixel_deviation_from_background_tb.sv
